@@ src/pmlrs_pkg.sv @@
// Shared types and constants for the stereo pan mixer and linear resampler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pmlrs_pkg;

    localparam int SAMPLE_W  = 24;   // Q1.23 source sample
    localparam int PAN_W     = 16;   // Q2.14 pan
    localparam int OUT_W     = 16;   // output sample
    localparam int GAIN_W    = 24;   // Q8.16 gain
    localparam int STEP_W    = 21;   // Q5.16 step
    localparam int WGT_W     = 16;   // pan weight, 0..32768
    localparam int PROD_W    = 41;   // sample times weight
    localparam int ACC_W     = 48;   // mix sums
    localparam int POS_W     = 22;   // Q6.16 position, always below 2^21
    localparam int FRAC_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_CNT_W = 6;

    localparam int DEF_MAX_SOURCES = 16;
    localparam int DEF_QUEUE_DEPTH = 2;
    localparam int MAX_OUT         = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd65536;
    localparam logic [STEP_W-1:0] STEP_MIN   = 21'd4096;
    localparam logic [STEP_W-1:0] STEP_MAX   = 21'd1048576;
    localparam logic [POS_W-1:0]  ONE_Q16    = 22'd65536;

    localparam logic signed [PAN_W-1:0] PAN_MIN = -16'sd16384;
    localparam logic signed [PAN_W-1:0] PAN_MAX = 16'sd16384;
    localparam logic [WGT_W-1:0]        WGT_FULL = 16'd32768;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESAMPLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd2;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic              resample_enable;
        logic [STEP_W-1:0] step;
    } t_cfg;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum_left;
        logic signed [ACC_W-1:0] sum_right;
        logic                    last_frame;
    } t_frame_sums;

endpackage

`default_nettype wire

@@ src/pmlrs_mix_front.sv @@
// Front end: accepts source items, weights them by pan and accumulates the step sums.
// Pushes the finished sums of each time step into the frame queue. Uses pmlrs_pkg.
`default_nettype none

module pmlrs_mix_front #(
    parameter int MAX_SOURCES = pmlrs_pkg::DEF_MAX_SOURCES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [pmlrs_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [pmlrs_pkg::PAN_W-1:0]    i_pan,
    input  logic                                  i_last_source,
    input  logic                                  i_last_frame,
    output logic                                  o_push,
    output pmlrs_pkg::t_frame_sums                o_push_data,
    input  logic                                  i_queue_full
);
    import pmlrs_pkg::*;

    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SOURCES);

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC} t_fstate;

    t_fstate                    r_state;
    logic signed [SAMPLE_W-1:0] r_smp;
    logic [WGT_W-1:0]           r_wr;
    logic                       r_last_src;
    logic                       r_last_frm;
    logic signed [PROD_W-1:0]   r_prod_l;
    logic signed [PROD_W-1:0]   r_prod_r;
    logic signed [ACC_W-1:0]    r_mix_l;
    logic signed [ACC_W-1:0]    r_mix_r;
    logic [CNT_W-1:0]           r_cnt;

    logic signed [PAN_W-1:0]    pan_c;
    logic signed [PAN_W:0]      pan_ofs;
    logic [WGT_W-1:0]           wl;
    logic                       take;
    logic signed [ACC_W-1:0]    n_mix_l;
    logic signed [ACC_W-1:0]    n_mix_r;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]  a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {{(ACC_W + 1 - PROD_W){b[PROD_W-1]}}, b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    always_comb begin
        if (i_pan < PAN_MIN) begin
            pan_c = PAN_MIN;
        end else if (i_pan > PAN_MAX) begin
            pan_c = PAN_MAX;
        end else begin
            pan_c = i_pan;
        end
        pan_ofs = {pan_c[PAN_W-1], pan_c} - {PAN_MIN[PAN_W-1], PAN_MIN};
    end

    assign wl         = WGT_FULL - r_wr;
    assign take       = r_cnt < CNT_MAX;
    assign n_mix_l    = take ? sat_add(r_mix_l, r_prod_l) : r_mix_l;
    assign n_mix_r    = take ? sat_add(r_mix_r, r_prod_r) : r_mix_r;
    assign o_in_ready = (r_state == F_IDLE);
    assign o_push     = (r_state == F_ACC) && r_last_src && !i_queue_full;

    always_comb begin
        o_push_data.sum_left   = n_mix_l;
        o_push_data.sum_right  = n_mix_r;
        o_push_data.last_frame = r_last_frm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_mix_l <= '0;
            r_mix_r <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_in_valid) begin
                        r_smp      <= i_sample;
                        r_wr       <= pan_ofs[WGT_W-1:0];
                        r_last_src <= i_last_source;
                        r_last_frm <= i_last_frame;
                        r_state    <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_prod_l <= r_smp * $signed({1'b0, wl});
                    r_prod_r <= r_smp * $signed({1'b0, r_wr});
                    r_state  <= F_ACC;
                end
                F_ACC: begin
                    if (r_last_src) begin
                        // hold until the queue has room for the finished step
                        if (!i_queue_full) begin
                            r_mix_l <= '0;
                            r_mix_r <= '0;
                            r_cnt   <= '0;
                            r_state <= F_IDLE;
                        end
                    end else begin
                        r_mix_l <= n_mix_l;
                        r_mix_r <= n_mix_r;
                        if (take) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ src/pmlrs_frame_queue.sv @@
// Short queue of per-step mix sums between the mixing front end and the resampling back end.
// Register-based, show-ahead output. Uses pmlrs_pkg.
`default_nettype none

module pmlrs_frame_queue #(
    parameter int DEPTH = pmlrs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pmlrs_pkg::t_frame_sums i_push_data,
    output logic                   o_full,
    input  logic                   i_pop,
    output pmlrs_pkg::t_frame_sums o_pop_data,
    output logic                   o_empty
);
    import pmlrs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

    t_frame_sums   r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full     = (r_count == CW'(DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("frame queue read while empty");

endmodule

`default_nettype wire

@@ src/pmlrs_resample_back.sv @@
// Back end: scales step sums by gain, saturates, then interpolates or passes frames out.
// One shared 24x24 multiplier for gain, two 17x17 for interpolation. Uses pmlrs_pkg.
`default_nettype none

module pmlrs_resample_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmlrs_pkg::t_cfg                     i_cfg,
    input  logic                                i_empty,
    output logic                                o_pop,
    input  pmlrs_pkg::t_frame_sums              i_pop_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [pmlrs_pkg::OUT_W-1:0]  o_left,
    output logic signed [pmlrs_pkg::OUT_W-1:0]  o_right,
    output logic                                o_run_last
);
    import pmlrs_pkg::*;

    localparam int HALF_W = ACC_W / 2;
    localparam int PP_W   = HALF_W + GAIN_W;
    localparam int SCL_W  = PP_W + 1 - 30;          // bits of sum*gain/2^54
    localparam int DIFF_W = OUT_W + 1;
    localparam int DPR_W  = 2 * DIFF_W;
    localparam int V_W    = DPR_W + 1;
    localparam int PS_W   = POS_W + 1;

    typedef enum logic [3:0] {
        B_IDLE, B_MUL, B_SCALE, B_CHECK, B_IMUL, B_EMIT, B_PASS, B_DONE
    } t_bstate;

    t_bstate                  r_state;
    logic                     r_last_frm;
    logic                     r_neg_l;
    logic                     r_neg_r;
    logic [ACC_W-1:0]         r_mag_l;
    logic [ACC_W-1:0]         r_mag_r;
    logic [1:0]               r_mcnt;
    logic [PP_W-1:0]          r_pp [4];
    logic signed [OUT_W-1:0]  r_cur_l;
    logic signed [OUT_W-1:0]  r_cur_r;
    logic signed [OUT_W-1:0]  r_prev_l;
    logic signed [OUT_W-1:0]  r_prev_r;
    logic                     r_have_prev;
    logic [POS_W-1:0]         r_pos;
    logic [OUT_CNT_W-1:0]     r_n;
    logic                     r_is_last;
    logic                     r_use_interp;
    logic signed [DPR_W-1:0]  r_dl;
    logic signed [DPR_W-1:0]  r_dr;
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_out_l;
    logic signed [OUT_W-1:0]  r_out_r;
    logic                     r_out_last;

    logic [HALF_W-1:0]        mul_a;
    logic [PP_W:0]            acc_l;
    logic [PP_W:0]            acc_r;
    logic [STEP_W-1:0]        st;
    logic [PS_W-1:0]          pos_st;
    logic [PS_W-1:0]          pos_st2;
    logic [PS_W-1:0]          limit;
    logic                     cond_now;
    logic                     cond_next;
    logic                     slot_free;
    logic                     out_load;
    logic signed [DIFF_W-1:0] diff_l;
    logic signed [DIFF_W-1:0] diff_r;
    logic signed [DIFF_W-1:0] frac;
    logic signed [V_W-1:0]    v_l;
    logic signed [V_W-1:0]    v_r;
    logic signed [V_W-1:0]    vt_l;
    logic signed [V_W-1:0]    vt_r;

    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic             neg,
        input logic [SCL_W-1:0] q
    );
        if (neg) begin
            if (q > SCL_W'(32768)) begin
                return OUT_MIN;
            end
            return OUT_W'(SCL_W'(0) - q);
        end
        if (q > SCL_W'(32767)) begin
            return OUT_MAX;
        end
        return OUT_W'(q);
    endfunction

    always_comb begin
        case (r_mcnt)
            2'd0:    mul_a = r_mag_l[HALF_W-1:0];
            2'd1:    mul_a = r_mag_l[ACC_W-1:HALF_W];
            2'd2:    mul_a = r_mag_r[HALF_W-1:0];
            2'd3:    mul_a = r_mag_r[ACC_W-1:HALF_W];
            default: mul_a = '0;
        endcase
    end

    // sum*gain = hi*gain*2^24 + lo*gain; result bits start at 2^54
    assign acc_l = {1'b0, r_pp[1]} + (PP_W + 1)'(r_pp[0] >> HALF_W);
    assign acc_r = {1'b0, r_pp[3]} + (PP_W + 1)'(r_pp[2] >> HALF_W);

    always_comb begin
        if (i_cfg.step < STEP_MIN) begin
            st = STEP_MIN;
        end else if (i_cfg.step > STEP_MAX) begin
            st = STEP_MAX;
        end else begin
            st = i_cfg.step;
        end
    end

    assign pos_st  = {1'b0, r_pos} + PS_W'(st);
    assign pos_st2 = pos_st + PS_W'(st);
    assign limit   = r_have_prev ? PS_W'({ONE_Q16, 1'b0}) : PS_W'(ONE_Q16);

    always_comb begin
        if (r_last_frm) begin
            cond_now  = pos_st <= limit;
            cond_next = pos_st2 <= limit;
        end else begin
            cond_now  = r_pos < ONE_Q16;
            cond_next = pos_st < PS_W'(ONE_Q16);
        end
    end

    assign diff_l = {r_cur_l[OUT_W-1], r_cur_l} - {r_prev_l[OUT_W-1], r_prev_l};
    assign diff_r = {r_cur_r[OUT_W-1], r_cur_r} - {r_prev_r[OUT_W-1], r_prev_r};
    assign frac   = $signed({1'b0, r_pos[FRAC_W-1:0]});

    // prev*2^16 + (cur-prev)*f, then truncate toward zero
    assign v_l  = {{(V_W - OUT_W - FRAC_W){r_prev_l[OUT_W-1]}}, r_prev_l, FRAC_W'(0)}
                + {r_dl[DPR_W-1], r_dl};
    assign v_r  = {{(V_W - OUT_W - FRAC_W){r_prev_r[OUT_W-1]}}, r_prev_r, FRAC_W'(0)}
                + {r_dr[DPR_W-1], r_dr};
    assign vt_l = v_l[V_W-1] ? v_l + V_W'(65535) : v_l;
    assign vt_r = v_r[V_W-1] ? v_r + V_W'(65535) : v_r;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign out_load    = slot_free && (r_state == B_EMIT || r_state == B_PASS);
    assign o_pop       = (r_state == B_IDLE) && !i_empty;
    assign o_out_valid = r_out_valid;
    assign o_left      = r_out_l;
    assign o_right     = r_out_r;
    assign o_run_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_prev_l    <= '0;
            r_prev_r    <= '0;
            r_have_prev <= 1'b0;
            r_pos       <= '0;
            r_n         <= '0;
            r_mcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_last_frm <= i_pop_data.last_frame;
                        r_neg_l    <= i_pop_data.sum_left[ACC_W-1];
                        r_neg_r    <= i_pop_data.sum_right[ACC_W-1];
                        r_mag_l    <= i_pop_data.sum_left[ACC_W-1]
                                    ? ACC_W'(-i_pop_data.sum_left) : i_pop_data.sum_left;
                        r_mag_r    <= i_pop_data.sum_right[ACC_W-1]
                                    ? ACC_W'(-i_pop_data.sum_right) : i_pop_data.sum_right;
                        r_mcnt     <= '0;
                        r_state    <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_pp[r_mcnt] <= mul_a * i_cfg.gain;
                    r_mcnt       <= r_mcnt + 1'b1;
                    if (r_mcnt == 2'd3) begin
                        r_state <= B_SCALE;
                    end
                end
                B_SCALE: begin
                    r_cur_l <= sat_out(r_neg_l, acc_l[PP_W:30]);
                    r_cur_r <= sat_out(r_neg_r, acc_r[PP_W:30]);
                    r_n     <= '0;
                    if (!i_cfg.resample_enable) begin
                        r_state <= B_PASS;
                    end else if (!r_last_frm && !r_have_prev) begin
                        r_state <= B_DONE;
                    end else begin
                        r_state <= B_CHECK;
                    end
                end
                B_CHECK: begin
                    r_state <= cond_now ? B_IMUL : B_DONE;
                end
                B_IMUL: begin
                    r_dl         <= diff_l * frac;
                    r_dr         <= diff_r * frac;
                    r_is_last    <= (r_n == OUT_CNT_W'(MAX_OUT - 1)) || !cond_next;
                    r_use_interp <= !r_last_frm || (r_have_prev && r_pos < ONE_Q16);
                    r_state      <= B_EMIT;
                end
                B_EMIT: begin
                    if (slot_free) begin
                        r_out_l     <= r_use_interp ? vt_l[FRAC_W+OUT_W-1:FRAC_W] : r_cur_l;
                        r_out_r     <= r_use_interp ? vt_r[FRAC_W+OUT_W-1:FRAC_W] : r_cur_r;
                        r_out_last  <= r_is_last;
                        r_pos       <= pos_st[POS_W-1:0];
                        r_n         <= r_n + 1'b1;
                        r_state     <= r_is_last ? B_DONE : B_CHECK;
                    end
                end
                B_PASS: begin
                    if (slot_free) begin
                        r_out_l     <= r_cur_l;
                        r_out_r     <= r_cur_r;
                        r_out_last  <= 1'b1;
                        r_state     <= B_IDLE;
                    end
                end
                B_DONE: begin
                    if (r_last_frm) begin
                        // end of stream: drop the interpolation history
                        r_pos       <= '0;
                        r_prev_l    <= '0;
                        r_prev_r    <= '0;
                        r_have_prev <= 1'b0;
                    end else begin
                        if (r_have_prev) begin
                            r_pos <= (r_pos >= ONE_Q16) ? r_pos - ONE_Q16 : '0;
                        end
                        r_prev_l    <= r_cur_l;
                        r_prev_r    <= r_cur_r;
                        r_have_prev <= 1'b1;
                    end
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_out_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= OUT_CNT_W'(MAX_OUT))
        else $error("more results than the per-item cap");

    a_prev_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have_prev |-> (r_prev_l == '0 && r_prev_r == '0))
        else $error("previous frame not cleared without history");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_IDLE) |-> (r_pos < POS_W'(STEP_MAX)))
        else $error("position left above one step between frames");

endmodule

`default_nettype wire

@@ src/pan_mix_linear_resampler_stereo.sv @@
// Top level of the stereo pan mixer with gain and linear-interpolation resampling.
// Holds the configuration registers; instantiates pmlrs_mix_front, pmlrs_frame_queue
// and pmlrs_resample_back. Uses pmlrs_pkg.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata: sample, pan; tlast, tuser
//   m_axis    out        m_axis_tvalid/tready       tdata: left, right; tlast
//   cfg       in         i_cfg_we (no wait)         i_cfg_index, i_cfg_wdata
//
// An input item passes the front end in order (register, pan-weight multiply,
// saturating accumulate). A finished step then passes the back end in order: pop,
// four passes through the shared 24x24 gain multiplier, scale and saturate.
// Each interpolated result goes through check, multiply and emit; pass-through emits directly.
// A resampled step then updates position and history before the next pop.
// Reset is synchronous and clears FSM states, counters, pointers and interpolation history.
// A two-frame queue lets the front keep mixing while the back end or the output stalls.
`default_nettype none

module pan_mix_linear_resampler_stereo #(
    parameter int MAX_SOURCES = pmlrs_pkg::DEF_MAX_SOURCES,
    parameter int QUEUE_DEPTH = pmlrs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [39:0]                         s_axis_tdata,  // source_sample, pan
    input  logic                                s_axis_tlast,  // last_source
    input  logic                                s_axis_tuser,  // last_frame
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [31:0]                         m_axis_tdata,  // left_out, right_out
    output logic                                m_axis_tlast,  // run_last
    input  logic                                i_cfg_we,
    input  logic [pmlrs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pmlrs_pkg::GAIN_W-1:0]        i_cfg_wdata
);
    import pmlrs_pkg::*;

    t_cfg                    r_cfg;
    logic                    push;
    logic                    pop;
    logic                    q_full;
    logic                    q_empty;
    t_frame_sums             push_data;
    t_frame_sums             pop_data;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain            <= GAIN_RESET;
            r_cfg.resample_enable <= 1'b0;
            r_cfg.step            <= STEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GAIN:     r_cfg.gain            <= i_cfg_wdata;
                CFG_RESAMPLE: r_cfg.resample_enable <= i_cfg_wdata[0];
                CFG_STEP:     r_cfg.step            <= i_cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    pmlrs_mix_front #(
        .MAX_SOURCES (MAX_SOURCES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_sample      ($signed(s_axis_tdata[SAMPLE_W-1:0])),
        .i_pan         ($signed(s_axis_tdata[SAMPLE_W+PAN_W-1:SAMPLE_W])),
        .i_last_source (s_axis_tlast),
        .i_last_frame  (s_axis_tuser),
        .o_push        (push),
        .o_push_data   (push_data),
        .i_queue_full  (q_full)
    );

    pmlrs_frame_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_empty     (q_empty)
    );

    pmlrs_resample_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_pop_data  (pop_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_left      (left_out),
        .o_right     (right_out),
        .o_run_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {right_out, left_out};

endmodule

`default_nettype wire

@@ bench/tb_pan_mix_linear_resampler_stereo.sv @@
// Self-checking bench for pan_mix_linear_resampler_stereo: mixes panned sources,
// predicts each stereo result and compares it with the m_axis stream.
// Depends on pmlrs_pkg and the top level of the block only.
`default_nettype none

module tb_pan_mix_linear_resampler_stereo;
    import pmlrs_pkg::*;

    localparam int     SRC_LIMIT      = DEF_MAX_SOURCES;
    localparam int     ITEM_TARGET    = 270;
    localparam int     IDLE_GAP       = 40;    // front plus back-end depth, with margin
    localparam int     TAIL_CYCLES    = 150;   // a full 32-result burst under stalls
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     REPORT_LIMIT   = 10;
    localparam longint UNIT_POS       = 65536;
    localparam longint ACC_TOP        = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_BOTTOM     = -ACC_TOP - 1;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        logic                    run_last;
    } t_pcm_frame;

    typedef enum int {RX_OPEN, RX_COIN, RX_QUARTER, RX_STARVE} t_rx_mode;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [39:0]          s_axis_tdata  = '0;   // source_sample, pan
    logic                 s_axis_tlast  = 1'b0; // last_source
    logic                 s_axis_tuser  = 1'b0; // last_frame
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;         // left_out, right_out
    logic                 m_axis_tlast;         // run_last
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [GAIN_W-1:0]    i_cfg_wdata   = '0;

    pan_mix_linear_resampler_stereo DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predictor copy of the configuration and the mixing/interpolation state
    logic [GAIN_W-1:0] cfg_gain     = GAIN_RESET;
    logic              cfg_resample = 1'b0;
    logic [STEP_W-1:0] cfg_step     = STEP_RESET;
    longint            sum_l        = 0;
    longint            sum_r        = 0;
    int                src_count    = 0;
    int                prev_l       = 0;
    int                prev_r       = 0;
    bit                prev_valid   = 1'b0;
    longint            frame_pos    = 0;

    t_pcm_frame  pcm_expected[$];
    int          mismatch_count = 0;
    int          items_mixed    = 0;
    int          burst_left     = 0;
    bit          tx_hold        = 1'b0;
    int          stall_cycles   = 0;
    t_rx_mode    rx_mode        = RX_OPEN;
    int unsigned rx_left        = 0;
    int unsigned rx_cyc         = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint acc_clamp(longint v);
        if (v > ACC_TOP) return ACC_TOP;
        if (v < ACC_BOTTOM) return ACC_BOTTOM;
        return v;
    endfunction

    // sum * gain / 2^54, truncated toward zero, saturated to 16 bits
    function automatic int pcm_from_sum(longint sum);
        logic [71:0] mag;
        logic [71:0] prod;
        mag  = (sum < 0) ? 72'(-sum) : 72'(sum);
        prod = (mag * {48'd0, cfg_gain}) >> 54;
        if (sum < 0) return (prod > 72'd32768) ? -32768 : -int'(prod[17:0]);
        return (prod > 72'd32767) ? 32767 : int'(prod[17:0]);
    endfunction

    function automatic int lerp(int a, int b, longint f);
        longint v;
        v = longint'(a) * (UNIT_POS - f) + longint'(b) * f;
        return int'(v / UNIT_POS);
    endfunction

    function automatic t_pcm_frame make_frame(int l, int r);
        t_pcm_frame fr;
        fr.left_out  = l[OUT_W-1:0];
        fr.right_out = r[OUT_W-1:0];
        fr.run_last  = 1'b0;
        return fr;
    endfunction

    task automatic predict_source(input logic signed [SAMPLE_W-1:0] smp,
                                  input logic signed [PAN_W-1:0] pn,
                                  input bit lsrc, input bit lfrm);
        longint     s;
        longint     p;
        longint     wr;
        longint     st;
        longint     lim;
        int         cl;
        int         cr;
        t_pcm_frame outs[$];
        s = smp;
        p = pn;
        if (p < -16384) p = -16384;
        if (p > 16384) p = 16384;
        if (src_count < SRC_LIMIT) begin
            wr    = p + 16384;
            sum_l = acc_clamp(sum_l + s * (32768 - wr));
            sum_r = acc_clamp(sum_r + s * wr);
            src_count++;
            items_mixed++;
        end
        if (!lsrc) return;

        cl        = pcm_from_sum(sum_l);
        cr        = pcm_from_sum(sum_r);
        sum_l     = 0;
        sum_r     = 0;
        src_count = 0;

        if (!cfg_resample) begin
            outs.push_back(make_frame(cl, cr));
        end else begin
            st = cfg_step;
            if (st < STEP_MIN) st = STEP_MIN;
            if (st > STEP_MAX) st = STEP_MAX;
            if (!lfrm) begin
                if (prev_valid) begin
                    while (frame_pos < UNIT_POS && outs.size() < MAX_OUT) begin
                        outs.push_back(make_frame(lerp(prev_l, cl, frame_pos),
                                                  lerp(prev_r, cr, frame_pos)));
                        frame_pos += st;
                    end
                    frame_pos = (frame_pos >= UNIT_POS) ? frame_pos - UNIT_POS : 0;
                end
                prev_l     = cl;
                prev_r     = cr;
                prev_valid = 1'b1;
            end else begin
                // hold the final frame once the position passes it
                lim = prev_valid ? 2 * UNIT_POS : UNIT_POS;
                while (frame_pos + st <= lim && outs.size() < MAX_OUT) begin
                    if (prev_valid && frame_pos < UNIT_POS)
                        outs.push_back(make_frame(lerp(prev_l, cl, frame_pos),
                                                  lerp(prev_r, cr, frame_pos)));
                    else
                        outs.push_back(make_frame(cl, cr));
                    frame_pos += st;
                end
                frame_pos  = 0;
                prev_l     = 0;
                prev_r     = 0;
                prev_valid = 1'b0;
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].run_last = 1'b1;
        foreach (outs[i]) pcm_expected.push_back(outs[i]);
    endtask

    task automatic send_source(input logic signed [SAMPLE_W-1:0] smp,
                               input logic signed [PAN_W-1:0] pn,
                               input bit lsrc, input bit lfrm);
        s_axis_tdata  <= {pn, smp};
        s_axis_tlast  <= lsrc;
        s_axis_tuser  <= lfrm;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_source(smp, pn, lsrc, lfrm);
        if (burst_left > 0) begin
            burst_left--;
            tx_hold = 1'b1;
        end else begin
            s_axis_tvalid <= 1'b0;
            tx_hold = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(0, 10);
        end
    endtask

    // drop valid and let every pending result and in-flight step drain
    task automatic wait_idle();
        if (tx_hold) begin
            s_axis_tvalid <= 1'b0;
            tx_hold = 1'b0;
        end
        while (pcm_expected.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_GAIN:     cfg_gain     = val;
            CFG_RESAMPLE: cfg_resample = val[0];
            CFG_STEP:     cfg_step     = val[STEP_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [PAN_W-1:0] pick_pan();
        int v;
        v = $urandom_range(0, 32768) - 16384;
        case ($urandom_range(0, 7))
            0:       return 16'hC000;
            1:       return 16'h4000;
            2:       return 16'($urandom());
            default: return v[PAN_W-1:0];
        endcase
    endfunction

    task automatic test_pass_through();
        send_source(24'h800000, 16'hC000, 1'b1, 1'b0);
        send_source(24'h7FFFFF, 16'h4000, 1'b1, 1'b1);
        // last_frame on an inner source is ignored
        send_source(24'd123456, 16'd5000, 1'b0, 1'b1);
        send_source(-24'sd777, -16'sd9000, 1'b1, 1'b0);
    endtask

    task automatic test_gain_extremes_and_source_limit();
        logic [PAN_W-1:0] pans[5];
        pans = '{16'h8000, 16'h7FFF, 16'hC000, 16'h4000, 16'h0000};
        wait_idle();
        write_reg(CFG_GAIN, 24'hFFFFFF);
        // the seventeenth source is past the limit but still closes the step
        for (int k = 0; k <= SRC_LIMIT; k++)
            send_source(24'h7FFFFF, pans[k % 5], k == SRC_LIMIT, 1'b0);
        wait_idle();
        write_reg(CFG_GAIN, 24'h000000);
        send_source(24'h7FFFFF, 16'h0000, 1'b1, 1'b0);
    endtask

    task automatic test_resample_directed();
        wait_idle();
        write_reg(CFG_GAIN, 24'hFFFFFF);
        write_reg(CFG_RESAMPLE, 24'd1);
        write_reg(CFG_STEP, 24'd65536);
        send_source(24'h7FFFFF, 16'hC000, 1'b1, 1'b0);
        send_source(24'h800000, 16'h4000, 1'b1, 1'b0);
        send_source(24'd4000000, 16'h0000, 1'b1, 1'b1);

        // step below the minimum: densest output, final frame hits the cap
        wait_idle();
        write_reg(CFG_STEP, 24'd0);
        send_source(24'h7FFFFF, 16'h0000, 1'b1, 1'b0);
        send_source(24'h800000, 16'd8000, 1'b1, 1'b0);
        send_source(24'h800000, 16'h0000, 1'b1, 1'b1);

        // step above the maximum: the final frames emit nothing
        wait_idle();
        write_reg(CFG_STEP, 24'h1FFFFF);
        send_source(24'h7FFFFF, 16'h0000, 1'b1, 1'b0);
        send_source(24'd1, 16'h0000, 1'b1, 1'b1);
        send_source(24'd5, 16'h0000, 1'b1, 1'b1);

        // lone final frame at unit step holds the frame once
        wait_idle();
        write_reg(CFG_STEP, 24'd65536);
        send_source(24'h7FFFFF, 16'h4000, 1'b1, 1'b1);
    endtask

    task automatic send_stream(input int n_frames);
        int n_src;
        bit closed;
        bit lsrc;
        closed = ($urandom_range(0, 5) != 0);
        for (int f = 0; f < n_frames; f++) begin
            n_src = ($urandom_range(0, 11) == 0) ? $urandom_range(15, 19)
                                                 : $urandom_range(1, 3);
            for (int k = 0; k < n_src; k++) begin
                lsrc = (k == n_src - 1);
                send_source(pick_sample(), pick_pan(), lsrc,
                            lsrc ? (closed && f == n_frames - 1) : 1'($urandom()));
            end
        end
    endtask

    task automatic test_random_streams();
        logic [GAIN_W-1:0] g;
        logic [STEP_W-1:0] st;
        while (items_mixed < ITEM_TARGET) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0:       g = 24'h000000;
                1:       g = 24'hFFFFFF;
                2:       g = 24'($urandom());
                default: g = 24'($urandom_range(24'h400000, 24'hFFFFFF));
            endcase
            case ($urandom_range(0, 7))
                0:       st = 21'($urandom_range(0, 4095));
                1:       st = 21'($urandom_range(1048577, 2097151));
                2:       st = STEP_MIN;
                3:       st = STEP_MAX;
                4:       st = STEP_RESET;
                default: st = 21'($urandom_range(4096, 200000));
            endcase
            write_reg(CFG_GAIN, g);
            write_reg(CFG_RESAMPLE, {23'($urandom()), 1'($urandom_range(0, 3) != 0)});
            write_reg(CFG_STEP, {3'($urandom()), st});
            repeat ($urandom_range(2, 5)) begin
                send_stream($urandom_range(1, 8));
                repeat ($urandom_range(0, 2))
                    send_source(pick_sample(), pick_pan(), 1'($urandom()), 1'($urandom()));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);
        test_pass_through();
        test_gain_extremes_and_source_limit();
        test_resample_directed();
        test_random_streams();
        wait_idle();
        repeat (TAIL_CYCLES - IDLE_GAP) @(posedge i_clk);
        if (mismatch_count == 0 && pcm_expected.size() == 0) begin
            $display("tb_pan_mix_linear_resampler_stereo OK");
        end else begin
            $display("tb_pan_mix_linear_resampler_stereo NOT OK");
        end
        $finish;
    end

    // receiver stalls follow a randomly chosen mode that is redrawn when its countdown ends
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        rx_cyc++;
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
            RX_QUARTER: m_axis_tready <= (rx_cyc[1:0] == 2'd0);
            default:    m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_pcm_frame want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pcm_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: left %0d right %0d last %0b",
                             $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                             m_axis_tlast);
            end else begin
                want = pcm_expected.pop_front();
                if (m_axis_tdata[15:0] !== want.left_out ||
                    m_axis_tdata[31:16] !== want.right_out ||
                    m_axis_tlast !== want.run_last) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result mismatch: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.left_out, want.right_out, want.run_last,
                                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                                 m_axis_tlast);
                end
            end
        end
    end

    // end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("tb_pan_mix_linear_resampler_stereo NOT OK");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ files.f @@
src/pmlrs_pkg.sv
src/pmlrs_mix_front.sv
src/pmlrs_frame_queue.sv
src/pmlrs_resample_back.sv
src/pan_mix_linear_resampler_stereo.sv
bench/tb_pan_mix_linear_resampler_stereo.sv
